// File: rtl/core/dxw_pkg.sv
// Shared types and constants for the junk-removing add-xor word decoder.
package dxw_pkg;

  // Field and register widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned POS_W    = LEN_W + 1;
  localparam int unsigned VB_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUNK_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LEN = 2'd3;

  // Register values after reset.
  localparam logic [WORD_W-1:0] XOR_KEY_RST   = '0;
  localparam logic [LEN_W-1:0]  CHUNK_LEN_RST = 16'd1;
  localparam logic [LEN_W-1:0]  JUNK_LEN_RST  = '0;
  localparam logic [WORD_W-1:0] TOTAL_LEN_RST = '0;

  // One decoded word as it leaves the block.
  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [WORD_W-1:0] word_offset;
    logic [VB_W-1:0]   valid_bytes;
    logic              last_word;
  } result_t;

endpackage

// File: rtl/core/dejunk_add_xor_word_decoder_core.sv
// Top level of the junk-removing add-xor word decoder.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  src_byte, first
//   out      output     out_valid/ out_stall out_word, word_offset, valid_bytes, last_word
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One source byte is taken in every cycle while in_stall is low; the stream
// state and the decoded word are worked out in the cycle of the transaction,
// and the word is held in the output register, or in the one-entry skid
// stage while the output stalls; in_stall rises only while the skid stage is full.
// Synchronous reset clears the stream state, the holding stages and sets the
// configuration registers to their reset values.
module dejunk_add_xor_word_decoder_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dxw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dxw_pkg::WORD_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dxw_pkg::BYTE_W-1:0]         src_byte,
  input  logic                               first,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dxw_pkg::WORD_W-1:0]         out_word,
  output logic [dxw_pkg::WORD_W-1:0]         word_offset,
  output logic [dxw_pkg::VB_W-1:0]           valid_bytes,
  output logic                               last_word
);

  // Configuration registers.
  logic [dxw_pkg::WORD_W-1:0] xor_key;
  logic [dxw_pkg::LEN_W-1:0]  chunk_len;
  logic [dxw_pkg::LEN_W-1:0]  junk_len;
  logic [dxw_pkg::WORD_W-1:0] total_len;

  // Stream state.
  logic [dxw_pkg::POS_W-1:0]  period_pos;
  logic [dxw_pkg::WORD_W-1:0] kept_count;
  logic [dxw_pkg::WORD_W-1:0] word_acc;
  logic [dxw_pkg::POS_W-1:0]  period_pos_next;
  logic [dxw_pkg::WORD_W-1:0] kept_count_next;
  logic [dxw_pkg::WORD_W-1:0] word_acc_next;

  // Output register and skid stage.
  dxw_pkg::result_t out_res;
  dxw_pkg::result_t skid_res;
  logic             skid_valid;

  // Decode datapath signals.
  logic                       in_accept;
  logic [dxw_pkg::POS_W-1:0]  pos_eff;
  logic [dxw_pkg::WORD_W-1:0] cnt_eff;
  logic [dxw_pkg::WORD_W-1:0] acc_eff;
  logic                       done;
  logic [dxw_pkg::POS_W-1:0]  period_len;
  logic [dxw_pkg::POS_W:0]    pos_inc;
  logic                       keep;
  logic [1:0]                 lane;
  logic [dxw_pkg::WORD_W-1:0] acc_base;
  logic [dxw_pkg::WORD_W-1:0] acc_ins;
  logic [dxw_pkg::WORD_W-1:0] cnt_inc;
  logic [dxw_pkg::WORD_W-1:0] offset;
  logic                       is_last;
  logic                       emit;
  dxw_pkg::result_t           res;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key   <= dxw_pkg::XOR_KEY_RST;
      chunk_len <= dxw_pkg::CHUNK_LEN_RST;
      junk_len  <= dxw_pkg::JUNK_LEN_RST;
      total_len <= dxw_pkg::TOTAL_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dxw_pkg::CFG_XOR_KEY:   xor_key   <= cfg_data;
        dxw_pkg::CFG_CHUNK_LEN: chunk_len <= cfg_data[dxw_pkg::LEN_W-1:0];
        dxw_pkg::CFG_JUNK_LEN:  junk_len  <= cfg_data[dxw_pkg::LEN_W-1:0];
        dxw_pkg::CFG_TOTAL_LEN: total_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // A first byte restarts the stream before it is handled.
  always_comb begin
    pos_eff = first ? '0 : period_pos;
    cnt_eff = first ? '0 : kept_count;
    acc_eff = first ? '0 : word_acc;
  end

  // Period bookkeeping and byte packing.
  always_comb begin
    done       = cnt_eff >= total_len;
    period_len = {1'b0, chunk_len} + {1'b0, junk_len};
    pos_inc    = {1'b0, pos_eff} + {{dxw_pkg::POS_W{1'b0}}, 1'b1};
    keep       = pos_eff < {1'b0, chunk_len};
    lane       = cnt_eff[1:0];
    acc_base   = (lane == 2'd0) ? '0 : acc_eff;
    acc_ins    = acc_base;
    acc_ins[{lane, 3'b000} +: dxw_pkg::BYTE_W] = src_byte;
    cnt_inc    = cnt_eff + 32'd1;
    offset     = {cnt_eff[dxw_pkg::WORD_W-1:2], 2'b00};
    is_last    = cnt_inc == total_len;
    emit       = !done && keep && ((lane == 2'd3) || is_last);

    res.out_word    = (acc_ins + offset) ^ (offset + xor_key);
    res.word_offset = offset;
    res.valid_bytes = {1'b0, lane} + 3'd1;
    res.last_word   = is_last;

    period_pos_next = pos_eff;
    kept_count_next = cnt_eff;
    word_acc_next   = acc_eff;
    if (!done) begin
      period_pos_next = (pos_inc >= {1'b0, period_len}) ? '0
                                                         : pos_inc[dxw_pkg::POS_W-1:0];
      if (keep) begin
        kept_count_next = cnt_inc;
        word_acc_next   = emit ? '0 : acc_ins;
      end
    end
  end

  // Stream state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_pos <= '0;
      kept_count <= '0;
      word_acc   <= '0;
    end else if (in_accept) begin
      period_pos <= period_pos_next;
      kept_count <= kept_count_next;
      word_acc   <= word_acc_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept && emit;
        out_res   <= res;
      end
    end else if (in_accept && emit) begin
      skid_valid <= 1'b1;
      skid_res   <= res;
    end
  end

  assign out_word    = out_res.out_word;
  assign word_offset = out_res.word_offset;
  assign valid_bytes = out_res.valid_bytes;
  assign last_word   = out_res.last_word;

endmodule

// File: rtl/core/dxw_checker.sv
// Port-level checker for the decoder core and its bind statement.
module dxw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dxw_pkg::WORD_W-1:0]    word_offset,
  input logic [dxw_pkg::VB_W-1:0]      valid_bytes,
  input logic                          last_word
);

  // A stalled output transaction stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  // Byte count of a word is between one and four.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_bytes >= 3'd1) && (valid_bytes <= 3'd4))
    else $error("valid_bytes out of range");

  // Only the word that ends the output may be partial.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (valid_bytes != 3'd4) |-> last_word)
    else $error("partial word that is not the last one");

  // Words start on a four-byte boundary.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_offset[1:0] == 2'b00))
    else $error("word offset not aligned");

endmodule

bind dejunk_add_xor_word_decoder_core dxw_checker u_dxw_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .word_offset (word_offset),
  .valid_bytes (valid_bytes),
  .last_word   (last_word)
);
